/* src/mesi_set_assoc_cache_controller_macros.svh */
// Assertion macros shared by the cache controller RTL.
`ifndef MESI_SET_ASSOC_CACHE_CONTROLLER_MACROS_SVH
`define MESI_SET_ASSOC_CACHE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MESI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MESI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mesi_pkg.sv */
// Shared types and constants for the MESI cache controller.
package mesi_pkg;

  // Field widths fixed by the channel definition
  localparam int unsigned LINE_TAG_W  = 20;
  localparam int unsigned SET_IDX_W   = 6;
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned COST_W      = 10;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned BLK_WORDS_W = 7;
  localparam int unsigned MEM_LAT_W   = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LATENCY = 2'd1;

  // Configuration reset values
  localparam logic [BLK_WORDS_W-1:0] BLOCK_WORDS_RST    = 7'd16;
  localparam logic [MEM_LAT_W-1:0]   MEMORY_LATENCY_RST = 8'd100;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PROC_RD   = 3'd0,
    ACT_PROC_WR   = 3'd1,
    ACT_SNP_RD    = 3'd2,
    ACT_SNP_RDX   = 3'd3,
    ACT_SNP_UPG   = 3'd4,
    ACT_SNP_FLUSH = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_RDX  = 2'd2,
    BUS_UPG  = 2'd3
  } bus_req_e;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_e;

endpackage

/* src/mesi_victim_sel.sv */
// Victim way selection: first invalid way, else oldest fill stamp.
module mesi_victim_sel import mesi_pkg::*; #(
  parameter int unsigned NUM_WAYS = 4,
  localparam int unsigned WayW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
  input  mesi_e [NUM_WAYS-1:0]               line_st_i,
  input  logic  [NUM_WAYS-1:0][STAMP_W-1:0]  stamp_i,
  output logic  [WayW-1:0]                   victim_o
);

  localparam int unsigned Lvl = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 0;
  localparam int unsigned PadW = 1 << Lvl;

  logic               node_ok    [Lvl+1][PadW];
  logic [STAMP_W-1:0] node_stamp [Lvl+1][PadW];
  logic [WayW-1:0]    node_idx   [Lvl+1][PadW];
  logic               inv_found;
  logic [WayW-1:0]    inv_way;

  // Find the lowest-numbered invalid way
  always_comb begin
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (line_st_i[w] == ST_I) begin
        inv_found = 1'b1;
        inv_way   = WayW'(w);
      end
    end
  end

  // Reduce stamps through a compare tree; the lower way wins on ties
  always_comb begin
    for (int l = 0; l <= Lvl; l++) begin
      for (int i = 0; i < PadW; i++) begin
        node_ok[l][i]    = 1'b0;
        node_stamp[l][i] = '0;
        node_idx[l][i]   = '0;
      end
    end
    for (int i = 0; i < PadW; i++) begin
      if (i < NUM_WAYS) begin
        node_ok[0][i]    = 1'b1;
        node_stamp[0][i] = stamp_i[i];
      end
      node_idx[0][i] = WayW'(i);
    end
    for (int l = 0; l < Lvl; l++) begin
      for (int j = 0; j < PadW / 2; j++) begin
        if (node_ok[l][2*j+1] &&
            (!node_ok[l][2*j] || (node_stamp[l][2*j+1] < node_stamp[l][2*j]))) begin
          node_ok[l+1][j]    = 1'b1;
          node_stamp[l+1][j] = node_stamp[l][2*j+1];
          node_idx[l+1][j]   = node_idx[l][2*j+1];
        end else begin
          node_ok[l+1][j]    = node_ok[l][2*j];
          node_stamp[l+1][j] = node_stamp[l][2*j];
          node_idx[l+1][j]   = node_idx[l][2*j];
        end
      end
    end
  end

  assign victim_o = inv_found ? inv_way : node_idx[Lvl][0];

endmodule

/* src/mesi_set_assoc_cache_controller.sv */
// Top level of the MESI set-associative cache tag and state controller.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ------------------------------------------
//  access   in         in_valid_i / in_ready_o   action, line_tag, set_index, other_has_copy
//  result   out        out_valid_o / out_ready_i hit, bus_request, writeback, victim_tag,
//                                                snoop_had_copy, cost_cycles
//  config   in         cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// One access per cycle sustained while results are taken; an accepted access is registered
// in the access stage and then in the result register, which drives the result outputs.
// The set row is read from the tag/state/stamp memories at the input transfer and written
// back when the access moves to the result register; a same-set follow-on access takes the
// written row through a bypass, so back-to-back accesses to one set need no bubble.
// Reset clears the per-set valid bits, so every set reads as all Invalid with zero stamps;
// no clearing pass is needed. A stalled result holds the access stage and the input.
module mesi_set_assoc_cache_controller import mesi_pkg::*; #(
  parameter int unsigned NUM_SETS  = 64,
  parameter int unsigned NUM_WAYS  = 4,
  parameter int unsigned TAG_WIDTH = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // access channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ACTION_W-1:0]    action_i,
  input  logic [LINE_TAG_W-1:0]  line_tag_i,
  input  logic [SET_IDX_W-1:0]   set_index_i,
  input  logic                   other_has_copy_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hit_o,
  output logic [1:0]             bus_request_o,
  output logic                   writeback_o,
  output logic [LINE_TAG_W-1:0]  victim_tag_o,
  output logic                   snoop_had_copy_o,
  output logic [COST_W-1:0]      cost_cycles_o
);

  `include "mesi_set_assoc_cache_controller_macros.svh"

  localparam int unsigned SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WayW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned SetIdxRange = 1 << SET_IDX_W;

  // configuration registers
  logic [BLK_WORDS_W-1:0] block_words_q;
  logic [MEM_LAT_W-1:0]   memory_latency_q;

  // handshake and pipeline control
  logic in_acc;
  logic s1_valid_q;
  logic s1_adv;
  logic out_valid_q;

  // access stage payload
  logic [ACTION_W-1:0]  act_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [SetW-1:0]      set_q;
  logic                 oth_q;

  // input set and tag mapping
  logic [SetW-1:0] set_lut [SetIdxRange];
  logic [SetW-1:0] in_set;
  logic [31:0]     in_tag_ext;

  // set row storage
  logic  [NUM_WAYS-1:0][TAG_WIDTH-1:0] tag_mem   [NUM_SETS];
  mesi_e [NUM_WAYS-1:0]                st_mem    [NUM_SETS];
  logic  [NUM_WAYS-1:0][STAMP_W-1:0]   stamp_mem [NUM_SETS];
  logic                                row_vld_q [NUM_SETS];

  // registered row read
  logic  [NUM_WAYS-1:0][TAG_WIDTH-1:0] rd_tag_q;
  mesi_e [NUM_WAYS-1:0]                rd_st_q;
  logic  [NUM_WAYS-1:0][STAMP_W-1:0]   rd_stamp_q;
  logic                                rd_vld_q;

  // current and updated row
  mesi_e [NUM_WAYS-1:0]                cur_st;
  logic  [NUM_WAYS-1:0][STAMP_W-1:0]   cur_stamp;
  logic  [NUM_WAYS-1:0][TAG_WIDTH-1:0] nxt_tag;
  mesi_e [NUM_WAYS-1:0]                nxt_st;
  logic  [NUM_WAYS-1:0][STAMP_W-1:0]   nxt_stamp;
  logic                                wr_en;
  logic                                byp_hit;

  // lookup
  logic [NUM_WAYS-1:0] match;
  logic                any_hit;
  logic [WayW-1:0]     hit_way;
  logic [WayW-1:0]     vic_way;
  logic [31:0]         vic_tag_ext;

  // fill sequence
  logic [STAMP_W-1:0] fill_seq_q;
  logic               fill_en;

  // result computation and register
  logic                  r_hit, r_wb, r_had;
  bus_req_e              r_req;
  logic [LINE_TAG_W-1:0] r_vtag;
  logic [COST_W-1:0]     r_cost;
  logic                  hit_q, wb_q, had_q;
  bus_req_e              req_q;
  logic [LINE_TAG_W-1:0] vtag_q;
  logic [COST_W-1:0]     cost_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_words_q    <= BLOCK_WORDS_RST;
      memory_latency_q <= MEMORY_LATENCY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BLOCK_WORDS:    block_words_q    <= cfg_data_i[BLK_WORDS_W-1:0];
        CFG_MEMORY_LATENCY: memory_latency_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // Fold the set index into the configured number of sets
  for (genvar g = 0; g < SetIdxRange; g++) begin : g_set_lut
    assign set_lut[g] = SetW'(g % NUM_SETS);
  end
  assign in_set     = set_lut[set_index_i];
  assign in_tag_ext = 32'(line_tag_i);

  // Advance when the result register is free or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = s1_adv;
  assign byp_hit    = wr_en && (set_q == in_set);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_seq_q  <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv && fill_en) begin
        fill_seq_q <= fill_seq_q + 32'd1;
      end
    end
  end

  // Capture the access
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_i;
      tag_q <= in_tag_ext[TAG_WIDTH-1:0];
      set_q <= in_set;
      oth_q <= other_has_copy_i;
    end
  end

  // Mark a set valid once its row has been written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        row_vld_q[s] <= 1'b0;
      end
    end else if (wr_en) begin
      row_vld_q[set_q] <= 1'b1;
    end
  end

  // Row memories: write back the updated row, read the next set with write bypass
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[set_q]   <= nxt_tag;
      st_mem[set_q]    <= nxt_st;
      stamp_mem[set_q] <= nxt_stamp;
    end
    if (in_acc) begin
      if (byp_hit) begin
        rd_tag_q   <= nxt_tag;
        rd_st_q    <= nxt_st;
        rd_stamp_q <= nxt_stamp;
        rd_vld_q   <= 1'b1;
      end else begin
        rd_tag_q   <= tag_mem[in_set];
        rd_st_q    <= st_mem[in_set];
        rd_stamp_q <= stamp_mem[in_set];
        rd_vld_q   <= row_vld_q[in_set];
      end
    end
  end

  // An unwritten set reads as all Invalid with zero stamps
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      cur_st[w]    = rd_vld_q ? rd_st_q[w] : ST_I;
      cur_stamp[w] = rd_vld_q ? rd_stamp_q[w] : '0;
    end
  end

  // Tag match on valid lines, lowest way first
  always_comb begin
    any_hit = 1'b0;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      match[w] = (cur_st[w] != ST_I) && (rd_tag_q[w] == tag_q);
      if (match[w]) begin
        any_hit = 1'b1;
        hit_way = WayW'(w);
      end
    end
  end

  mesi_victim_sel #(
    .NUM_WAYS (NUM_WAYS)
  ) u_victim_sel (
    .line_st_i (cur_st),
    .stamp_i   (cur_stamp),
    .victim_o  (vic_way)
  );

  assign vic_tag_ext = 32'(rd_tag_q[vic_way]);

  // Apply the access to the row and form the result
  always_comb begin
    nxt_tag   = rd_tag_q;
    nxt_st    = cur_st;
    nxt_stamp = cur_stamp;
    fill_en   = 1'b0;
    r_hit     = 1'b0;
    r_req     = BUS_NONE;
    r_wb      = 1'b0;
    r_vtag    = '0;
    r_had     = 1'b0;
    r_cost    = '0;
    case (act_q)
      ACT_PROC_RD, ACT_PROC_WR: begin
        if (any_hit) begin
          r_hit = 1'b1;
          if (act_q == ACT_PROC_WR) begin
            if (cur_st[hit_way] == ST_S) begin
              r_req = BUS_UPG;
            end
            nxt_st[hit_way] = ST_M;
          end
        end else begin
          // fill the victim; the cost tops out at 510, under the 10-bit ceiling
          if (cur_st[vic_way] == ST_M) begin
            r_wb   = 1'b1;
            r_vtag = vic_tag_ext[LINE_TAG_W-1:0];
            r_cost = COST_W'(memory_latency_q);
          end
          nxt_tag[vic_way]   = tag_q;
          nxt_stamp[vic_way] = fill_seq_q;
          fill_en            = 1'b1;
          r_cost = r_cost + (oth_q ? (COST_W'(block_words_q) << 1)
                                   : COST_W'(memory_latency_q));
          if (act_q == ACT_PROC_RD) begin
            nxt_st[vic_way] = oth_q ? ST_S : ST_E;
            r_req           = BUS_RD;
          end else begin
            nxt_st[vic_way] = ST_M;
            r_req           = BUS_RDX;
          end
        end
      end
      ACT_SNP_RD, ACT_SNP_RDX, ACT_SNP_UPG, ACT_SNP_FLUSH: begin
        if (any_hit) begin
          r_had           = 1'b1;
          nxt_st[hit_way] = (act_q == ACT_SNP_RD) ? ST_S : ST_I;
        end
      end
      default: ;
    endcase
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      hit_q  <= r_hit;
      req_q  <= r_req;
      wb_q   <= r_wb;
      vtag_q <= r_vtag;
      had_q  <= r_had;
      cost_q <= r_cost;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign bus_request_o    = req_q;
  assign writeback_o      = wb_q;
  assign victim_tag_o     = vtag_q;
  assign snoop_had_copy_o = had_q;
  assign cost_cycles_o    = cost_q;

  // Check pipeline and state bookkeeping
  `MESI_ASSERT_NEXT(a_acc_loads_stage, in_acc, s1_valid_q, "accepted access lost")
  `MESI_ASSERT_NEXT(a_fill_seq_step, s1_adv && fill_en,
                    fill_seq_q == $past(fill_seq_q) + 32'd1, "fill sequence skipped")
  `MESI_ASSERT_NEXT(a_bypass_valid, in_acc && byp_hit, rd_vld_q, "bypassed row not valid")
  `MESI_ASSERT_NOW(a_snoop_quiet, out_valid_o && snoop_had_copy_o,
                   !hit_o && (bus_request_o == BUS_NONE) && (cost_cycles_o == '0),
                   "snoop result carries processor fields")

endmodule

/* sim/mesi_cache_checker.sv */
`timescale 1ns / 1ps
// Result checker for the MESI cache controller: tracks tags and line states, predicts results.
module mesi_cache_checker import mesi_pkg::*; #(
  parameter int unsigned NUM_SETS = 64,
  parameter int unsigned NUM_WAYS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_o,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [LINE_TAG_W-1:0] line_tag_i,
  input  logic [SET_IDX_W-1:0]  set_index_i,
  input  logic                  other_has_copy_i,
  input  logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic                  hit_o,
  input  logic [1:0]            bus_request_o,
  input  logic                  writeback_o,
  input  logic [LINE_TAG_W-1:0] victim_tag_o,
  input  logic                  snoop_had_copy_o,
  input  logic [COST_W-1:0]     cost_cycles_o,
  output int                    err_count_o,
  output int                    outstanding_o
);

  localparam int unsigned LINES      = NUM_SETS * NUM_WAYS;
  localparam int unsigned COST_MAX   = 1023;
  localparam int          REPORT_CAP = 100;

  typedef struct packed {
    logic                  hit;
    bus_req_e              bus_req;
    logic                  wb;
    logic [LINE_TAG_W-1:0] victim_tag;
    logic                  had_copy;
    logic [COST_W-1:0]     cost;
  } access_result_t;

  // Shadow copy of the tag, coherence state and fill order of every line
  logic [LINE_TAG_W-1:0]  tag_mem   [LINES];
  mesi_e                  state_mem [LINES];
  logic [STAMP_W-1:0]     stamp_mem [LINES];
  logic [STAMP_W-1:0]     next_stamp;
  logic [BLK_WORDS_W-1:0] blk_words;
  logic [MEM_LAT_W-1:0]   mem_lat;
  access_result_t         due_results [$];

  initial begin
    err_count_o   = 0;
    outstanding_o = 0;
  end

  // Return the way holding a valid copy of the tag, or -1
  function automatic int find_way(int unsigned base, logic [LINE_TAG_W-1:0] tag);
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (state_mem[base + w] != ST_I && tag_mem[base + w] == tag) return w;
    end
    return -1;
  endfunction

  // First invalid way, else the oldest fill (lowest way on ties)
  function automatic int unsigned pick_victim(int unsigned base);
    int unsigned oldest;
    oldest = 0;
    for (int unsigned w = 0; w < NUM_WAYS; w++) begin
      if (state_mem[base + w] == ST_I) return w;
    end
    for (int unsigned w = 1; w < NUM_WAYS; w++) begin
      if (stamp_mem[base + w] < stamp_mem[base + oldest]) oldest = w;
    end
    return oldest;
  endfunction

  // Apply one access to the shadow state and return the result it produces
  function automatic access_result_t resolve_access(logic [ACTION_W-1:0] act,
                                                    logic [LINE_TAG_W-1:0] tag,
                                                    logic [SET_IDX_W-1:0] set_idx,
                                                    logic other);
    access_result_t res;
    int unsigned    base;
    int unsigned    idx;
    int unsigned    cost;
    int             way;
    res         = '0;
    res.bus_req = BUS_NONE;
    cost        = 0;
    base        = (int'(set_idx) % NUM_SETS) * NUM_WAYS;
    way         = find_way(base, tag);
    if (act == ACT_PROC_RD || act == ACT_PROC_WR) begin
      if (way >= 0) begin
        idx     = base + way;
        res.hit = 1'b1;
        if (act == ACT_PROC_WR) begin
          if (state_mem[idx] == ST_S) res.bus_req = BUS_UPG;
          state_mem[idx] = ST_M;
        end
      end else begin
        idx = base + pick_victim(base);
        // Dirty victim goes back to memory first
        if (state_mem[idx] == ST_M) begin
          res.wb         = 1'b1;
          res.victim_tag = tag_mem[idx];
          cost           = int'(mem_lat);
        end
        tag_mem[idx]   = tag;
        stamp_mem[idx] = next_stamp;
        next_stamp     = next_stamp + 1'b1;
        cost += other ? 2 * int'(blk_words) : int'(mem_lat);
        if (act == ACT_PROC_RD) begin
          state_mem[idx] = other ? ST_S : ST_E;
          res.bus_req    = BUS_RD;
        end else begin
          state_mem[idx] = ST_M;
          res.bus_req    = BUS_RDX;
        end
        res.cost = (cost > COST_MAX) ? COST_MAX[COST_W-1:0] : cost[COST_W-1:0];
      end
    end else if (act >= ACT_SNP_RD && act <= ACT_SNP_FLUSH) begin
      if (way >= 0) begin
        idx            = base + way;
        res.had_copy   = 1'b1;
        state_mem[idx] = (act == ACT_SNP_RD) ? ST_S : ST_I;
      end
    end
    return res;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      if (err_count_o < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      err_count_o++;
    end
  endtask

  // Track config writes, check result transfers, predict access transfers
  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        state_mem[i] = ST_I;
        stamp_mem[i] = '0;
      end
      next_stamp = '0;
      blk_words  = BLOCK_WORDS_RST;
      mem_lat    = MEMORY_LATENCY_RST;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BLOCK_WORDS: begin
            blk_words = cfg_data_i[BLK_WORDS_W-1:0];
          end
          CFG_MEMORY_LATENCY: begin
            mem_lat = cfg_data_i[MEM_LAT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          if (err_count_o < REPORT_CAP)
            $display("%0t: result transfer with none expected, expected none, actual hit=%0h",
                     $time, hit_o);
          err_count_o++;
        end else begin
          want = due_results.pop_front();
          flag_field("hit", want.hit, hit_o);
          flag_field("bus_request", want.bus_req, bus_request_o);
          flag_field("writeback", want.wb, writeback_o);
          flag_field("victim_tag", want.victim_tag, victim_tag_o);
          flag_field("snoop_had_copy", want.had_copy, snoop_had_copy_o);
          flag_field("cost_cycles", want.cost, cost_cycles_o);
        end
      end
      if (in_valid_i && in_ready_o)
        due_results.push_back(resolve_access(action_i, line_tag_i, set_index_i,
                                             other_has_copy_i));
    end
    outstanding_o = due_results.size();
  end

endmodule

/* sim/mesi_set_assoc_cache_controller_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the MESI cache controller: clock, reset, stimulus and verdict.
module mesi_set_assoc_cache_controller_tb;
  import mesi_pkg::*;

  localparam int unsigned NUM_SETS    = 64;
  localparam int unsigned NUM_WAYS    = 4;
  localparam int          NUM_PHASES  = 5;
  localparam int          PHASE_ITEMS = 227;
  localparam int          TAG_POOL    = 6;
  localparam int          HOT_SETS    = 3;
  // Action codes outside the defined set; the block must answer them with all zeros
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i       = '0;
  logic                  in_valid_i       = 1'b0;
  logic [ACTION_W-1:0]   action_i         = '0;
  logic [LINE_TAG_W-1:0] line_tag_i       = '0;
  logic [SET_IDX_W-1:0]  set_index_i      = '0;
  logic                  other_has_copy_i = 1'b0;
  logic                  out_ready_i      = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  hit_o;
  logic [1:0]            bus_request_o;
  logic                  writeback_o;
  logic [LINE_TAG_W-1:0] victim_tag_o;
  logic                  snoop_had_copy_o;
  logic [COST_W-1:0]     cost_cycles_o;

  int                    err_count;
  int                    outstanding;
  int                    rx_hold  = 0;
  bit                    rx_burst = 1'b0;
  bit                    tx_burst = 1'b0;
  logic [LINE_TAG_W-1:0] tag_pool [TAG_POOL];
  logic [SET_IDX_W-1:0]  hot_sets [HOT_SETS];

  mesi_set_assoc_cache_controller #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .line_tag_i       (line_tag_i),
    .set_index_i      (set_index_i),
    .other_has_copy_i (other_has_copy_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .bus_request_o    (bus_request_o),
    .writeback_o      (writeback_o),
    .victim_tag_o     (victim_tag_o),
    .snoop_had_copy_o (snoop_had_copy_o),
    .cost_cycles_o    (cost_cycles_o)
  );

  mesi_cache_checker #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .line_tag_i       (line_tag_i),
    .set_index_i      (set_index_i),
    .other_has_copy_i (other_has_copy_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .bus_request_o    (bus_request_o),
    .writeback_o      (writeback_o),
    .victim_tag_o     (victim_tag_o),
    .snoop_had_copy_o (snoop_had_copy_o),
    .cost_cycles_o    (cost_cycles_o),
    .err_count_o      (err_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Stall the result channel at random, with occasional stall-free stretches
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= rx_hold - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 199) == 0) rx_burst <= !rx_burst;
      rx_hold <= pick_gap(rx_burst);
    end
  end

  // Present one access after a random gap and hold it until the transfer
  task automatic send_access(input logic [ACTION_W-1:0] act, input logic [LINE_TAG_W-1:0] tag,
                             input logic [SET_IDX_W-1:0] set_idx, input logic other);
    int gap;
    gap = pick_gap(tx_burst);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    line_tag_i       <= tag;
    set_index_i      <= set_idx;
    other_has_copy_i <= other;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold off until every predicted result has been seen
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly hot sets and a small tag pool so hits, evictions and snoop matches are common
  task automatic random_access();
    int                    r;
    logic [ACTION_W-1:0]   act;
    logic [LINE_TAG_W-1:0] tag;
    logic [SET_IDX_W-1:0]  set_idx;
    r = $urandom_range(0, 99);
    if (r < 30)      act = ACT_PROC_RD;
    else if (r < 60) act = ACT_PROC_WR;
    else if (r < 69) act = ACT_SNP_RD;
    else if (r < 78) act = ACT_SNP_RDX;
    else if (r < 87) act = ACT_SNP_UPG;
    else if (r < 96) act = ACT_SNP_FLUSH;
    else             act = $urandom_range(0, 1) ? ACT_UNUSED_HI : ACT_UNUSED_LO;
    tag     = ($urandom_range(0, 9) != 0) ? tag_pool[$urandom_range(0, TAG_POOL - 1)]
                                          : LINE_TAG_W'($urandom);
    set_idx = ($urandom_range(0, 6) != 0) ? hot_sets[$urandom_range(0, HOT_SETS - 1)]
                                          : SET_IDX_W'($urandom);
    send_access(act, tag, set_idx, 1'($urandom));
  endtask

  initial begin
    logic [BLK_WORDS_W-1:0] bw;
    logic [MEM_LAT_W-1:0]   lat;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: full MESI walk on the top set with reset register values
    send_access(ACT_PROC_RD,   20'hFFFFF, 6'd63, 1'b0);  // miss, fill Exclusive
    send_access(ACT_PROC_RD,   20'hFFFFF, 6'd63, 1'b1);  // read hit
    send_access(ACT_PROC_WR,   20'hFFFFF, 6'd63, 1'b0);  // silent Exclusive to Modified
    send_access(ACT_SNP_RD,    20'hFFFFF, 6'd63, 1'b0);  // Modified demoted to Shared
    send_access(ACT_PROC_WR,   20'hFFFFF, 6'd63, 1'b1);  // Shared write hit, upgrade
    send_access(ACT_PROC_RD,   20'h00000, 6'd63, 1'b1);  // miss, fill Shared
    send_access(ACT_PROC_WR,   20'h00001, 6'd63, 1'b1);  // write miss, cache-to-cache cost
    send_access(ACT_PROC_RD,   20'h00002, 6'd63, 1'b0);  // set now full
    send_access(ACT_PROC_RD,   20'h00003, 6'd63, 1'b0);  // evict oldest, dirty writeback
    send_access(ACT_PROC_RD,   20'h00004, 6'd63, 1'b1);  // evict next oldest, clean
    send_access(ACT_SNP_RDX,   20'h00003, 6'd63, 1'b0);
    send_access(ACT_SNP_UPG,   20'h00001, 6'd63, 1'b1);
    send_access(ACT_SNP_FLUSH, 20'h00002, 6'd63, 1'b0);
    send_access(ACT_SNP_RD,    20'h55555, 6'd63, 1'b1);  // snoop miss
    send_access(ACT_PROC_RD,   20'h00002, 6'd63, 1'b0);  // refill lowest invalid way
    send_access(ACT_UNUSED_LO, 20'hAAAAA, 6'd21, 1'b1);
    send_access(ACT_UNUSED_HI, 20'h0F0F0, 6'd42, 1'b0);
    send_access(ACT_PROC_WR,   20'h00000, 6'd0,  1'b0);
    send_access(ACT_PROC_RD,   20'h00000, 6'd0,  1'b1);
    send_access(ACT_SNP_FLUSH, 20'h00000, 6'd0,  1'b1);
    send_access(ACT_PROC_RD,   20'hAAAAA, 6'd0,  1'b1);

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0:       begin bw = 7'd1;  lat = 8'd255; end
        1:       begin bw = 7'd64; lat = 8'd0;   end
        3:       begin bw = 7'd64; lat = 8'd255; end
        4:       begin bw = 7'd1;  lat = 8'd0;   end
        default: begin
          bw  = BLK_WORDS_W'($urandom_range(1, 64));
          lat = MEM_LAT_W'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_BLOCK_WORDS, CFG_DATA_W'(bw));
      write_reg(CFG_MEMORY_LATENCY, lat);
      for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = LINE_TAG_W'($urandom);
      for (int i = 0; i < HOT_SETS; i++) hot_sets[i] = SET_IDX_W'($urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        random_access();
      end
    end

    // Let the last results come out, then judge
    tx_burst = 1'b0;
    drain();
    repeat (10) @(negedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* mesi_set_assoc_cache_controller.f */
+incdir+src
src/mesi_pkg.sv
src/mesi_victim_sel.sv
src/mesi_set_assoc_cache_controller.sv
sim/mesi_cache_checker.sv
sim/mesi_set_assoc_cache_controller_tb.sv
